/* hdl/whacc_pkg.sv */
// shared types, codes and saturating helpers for the weighted histogram accumulator
package whacc_pkg;

   localparam int VAL_W    = 48;
   localparam int WEIGHT_W = 32;
   localparam int RATIO_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int PROB_W   = 18;
   localparam int QUOT_W   = PROB_W + 1;

   typedef enum logic [1:0] {
      OP_STORE     = 2'd0,
      OP_STORE_BAD = 2'd1,
      OP_SET_BAD   = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_BAD_INDEX     = 2'd1,
      ST_ZERO_INTEGRAL = 2'd2,
      ST_SATURATED     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_STORE,
      S_READ,
      S_DIV,
      S_SUB,
      S_MUL,
      S_SCALE,
      S_ADD,
      S_OUT
   } state_type;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type VAL_MAX = val_type'({1'b0, {(VAL_W-1){1'b1}}});
   localparam val_type VAL_MIN = val_type'({1'b1, {(VAL_W-1){1'b0}}});

   localparam logic [QUOT_W-1:0] QUOT_POS_MAX = QUOT_W'((1 << (PROB_W-1)) - 1);
   localparam logic [QUOT_W-1:0] QUOT_NEG_MAX = QUOT_W'(1 << (PROB_W-1));

   typedef struct packed {
      val_type value;
      logic    sat;
   } sat_val_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic              ovf;
   } div_rsp_type;

   typedef struct packed {
      logic    done;
      val_type value;
      logic    sat;
   } scale_rsp_type;

   function automatic sat_val_type clamp_sum(input logic signed [VAL_W:0] sum);
      sat_val_type r;
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         r.sat   = 1'b1;
         r.value = sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = sum[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic sat_val_type add_sat(input val_type a, input val_type b);
      logic signed [VAL_W:0] sum;
      sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      return clamp_sum(sum);
   endfunction

   function automatic sat_val_type sub_sat(input val_type a, input val_type b);
      logic signed [VAL_W:0] diff;
      diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      return clamp_sum(diff);
   endfunction

   // magnitude of the most negative value comes out as 2^47, still exact unsigned
   function automatic logic [VAL_W-1:0] mag(input val_type a);
      logic [VAL_W-1:0] u;
      u = a;
      return a[VAL_W-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

/* hdl/whacc_req_if.sv */
// request channel: operation beat into the accumulator
interface whacc_req_if #(parameter int BINS = 256) ();
   localparam int IDX_W = $clog2(BINS + 1);

   logic                                   valid;
   logic                                   ready;
   whacc_pkg::op_type                      operation;
   logic [IDX_W-1:0]                       bin_index;
   logic signed [whacc_pkg::WEIGHT_W-1:0]  weight;
   logic [whacc_pkg::RATIO_W-1:0]          ratio;

   modport source (output valid, output operation, output bin_index, output weight,
                   output ratio, input ready);
   modport sink (input valid, input operation, input bin_index, input weight,
                 input ratio, output ready);
   modport monitor (input valid, input ready, input operation, input bin_index,
                    input weight, input ratio);
endinterface

/* hdl/whacc_rsp_if.sv */
// response channel: one result beat per request
interface whacc_rsp_if ();
   logic                                 valid;
   logic                                 ready;
   logic signed [whacc_pkg::VAL_W-1:0]   bin_value;
   logic signed [whacc_pkg::PROB_W-1:0]  probability;
   logic signed [whacc_pkg::VAL_W-1:0]   total;
   whacc_pkg::status_type                status;
   logic                                 bad_overwritten;

   modport source (output valid, output bin_value, output probability, output total,
                   output status, output bad_overwritten, input ready);
   modport sink (input valid, input bin_value, input probability, input total,
                 input status, input bad_overwritten, output ready);
   modport monitor (input valid, input ready, input bin_value, input probability,
                    input total, input status, input bad_overwritten);
endinterface

/* hdl/whacc_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module whacc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic                              rd_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/whacc_div.sv */
// restoring divider: (num << 16) / den, one quotient bit per cycle, overflow flagged
module whacc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [whacc_pkg::VAL_W-1:0]   num,
   input  logic [whacc_pkg::VAL_W-1:0]   den,
   output whacc_pkg::div_rsp_type        rsp
);
   localparam int QW    = whacc_pkg::QUOT_W;
   localparam int R_W   = whacc_pkg::VAL_W + whacc_pkg::FRAC_W;
   localparam int D_W   = whacc_pkg::VAL_W + QW - 1;
   localparam int C_W   = whacc_pkg::VAL_W + QW;
   localparam int CNT_W = $clog2(QW);

   logic [R_W-1:0]   rem_ff;
   logic [D_W-1:0]   dsh_ff;
   logic [QW-1:0]    quot_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic             fits;
   logic [D_W-1:0]   rem_diff;
   logic             ovf_in;

   assign fits     = D_W'(rem_ff) >= dsh_ff;
   assign rem_diff = D_W'(rem_ff) - dsh_ff;
   // quotient needs more than QW bits when num << 16 reaches den << QW
   assign ovf_in   = C_W'({num, {whacc_pkg::FRAC_W{1'b0}}}) >= {den, {QW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {num, {whacc_pkg::FRAC_W{1'b0}}};
         dsh_ff  <= {den, {(QW-1){1'b0}}};
         quot_ff <= '0;
         ovf_ff  <= ovf_in;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_diff[R_W-1:0];
         end
         quot_ff <= {quot_ff[QW-2:0], fits};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.ovf  = ovf_ff;
endmodule

/* hdl/whacc_scale.sv */
// integral times unsigned q16.16 ratio on magnitudes, two partial products, clamped
module whacc_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  whacc_pkg::val_type              integ,
   input  logic [whacc_pkg::RATIO_W-1:0]   ratio,
   output whacc_pkg::scale_rsp_type        rsp
);
   localparam int LO_W = 32;
   localparam int HI_W = whacc_pkg::VAL_W - LO_W;
   localparam int PH_W = HI_W + whacc_pkg::RATIO_W;
   localparam int PL_W = LO_W + whacc_pkg::RATIO_W;
   localparam int P_W  = PH_W + whacc_pkg::FRAC_W;
   localparam logic [P_W-1:0] P_NEG_LIM = P_W'(1) << (whacc_pkg::VAL_W - 1);
   localparam logic [P_W-1:0] P_POS_LIM = P_NEG_LIM - 1'b1;

   logic [whacc_pkg::VAL_W-1:0] m;
   logic [PH_W-1:0]             prod_hi_ff;
   logic [PL_W-1:0]             prod_lo_ff;
   logic                        neg_ff;
   logic                        stage_ff;
   logic                        done_ff;
   whacc_pkg::val_type          value_ff;
   logic                        sat_ff;

   logic [P_W-1:0]              p;
   whacc_pkg::val_type          value_in;
   logic                        sat_in;

   assign m = whacc_pkg::mag(integ);
   assign p = {prod_hi_ff, {whacc_pkg::FRAC_W{1'b0}}}
            + P_W'(prod_lo_ff >> whacc_pkg::FRAC_W);

   always_comb begin
      if (neg_ff) begin
         sat_in   = p > P_NEG_LIM;
         value_in = sat_in ? whacc_pkg::VAL_MIN
                           : whacc_pkg::val_type'(-p[whacc_pkg::VAL_W-1:0]);
      end else begin
         sat_in   = p > P_POS_LIM;
         value_in = sat_in ? whacc_pkg::VAL_MAX
                           : whacc_pkg::val_type'(p[whacc_pkg::VAL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff     <= integ[whacc_pkg::VAL_W-1];
         prod_hi_ff <= PH_W'(m[whacc_pkg::VAL_W-1:LO_W]) * PH_W'(ratio);
         prod_lo_ff <= PL_W'(m[LO_W-1:0]) * PL_W'(ratio);
      end
      if (stage_ff) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.sat   = sat_ff;
endmodule

/* hdl/weighted_histogram_accumulator.sv */
// Weighted histogram accumulator: BINS signed Q32.16 bin totals held in a RAM, an extra bad
// bin and the running integral held in registers, all saturating at 48 bits. After reset a
// clearing pass writes zero to every RAM entry, one per cycle, so no request is taken until
// the pass has reached the last entry. Requests are handled one at a time; a result waits
// in an output register while the next request is already taken. From accept to result
// valid, store and store-bad go through RAM read, update and write-back, and output;
// read-bin goes straight to output on an invalid index or a zero integral and otherwise
// waits on the 19-step quotient loop of the divider; set-bad-bin waits on the two stage
// partial-product multiplier.
module weighted_histogram_accumulator #(
   parameter int BINS = 256
) (
   input  logic          clock,
   input  logic          reset,
   whacc_req_if.sink     req_bus,
   whacc_rsp_if.source   rsp_bus
);
   localparam int IDX_W = $clog2(BINS + 1);
   localparam int AW    = (BINS > 1) ? $clog2(BINS) : 1;
   localparam logic [IDX_W-1:0] BAD_IDX  = IDX_W'(BINS);
   localparam logic [AW-1:0]    LAST_ADR = AW'(BINS - 1);
   localparam int VW = whacc_pkg::VAL_W;
   localparam int PW = whacc_pkg::PROB_W;
   localparam int QW = whacc_pkg::QUOT_W;

   whacc_pkg::state_type   state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic signed [whacc_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [whacc_pkg::RATIO_W-1:0]         ratio_ff, ratio_in;
   whacc_pkg::val_type     integ_ff, integ_in;
   whacc_pkg::val_type     bad_ff, bad_in;
   logic [AW-1:0]          clr_ff, clr_in;

   whacc_pkg::val_type     res_bval_ff, res_bval_in;
   logic signed [PW-1:0]   res_prob_ff, res_prob_in;
   whacc_pkg::status_type  res_status_ff, res_status_in;
   logic                   res_sat_ff, res_sat_in;
   logic                   res_over_ff, res_over_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   whacc_pkg::val_type     rsp_bval_ff, rsp_bval_in;
   logic signed [PW-1:0]   rsp_prob_ff, rsp_prob_in;
   whacc_pkg::val_type     rsp_total_ff, rsp_total_in;
   whacc_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                   rsp_over_ff, rsp_over_in;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VW-1:0]          mem_wdata;
   logic                   mem_re;
   logic [VW-1:0]          mem_rdata;

   logic                   div_start;
   whacc_pkg::div_rsp_type div_rsp;
   logic                   scale_start;
   whacc_pkg::scale_rsp_type scale_rsp;

   logic                   req_ready;
   logic                   out_free;
   logic                   idx_bad;
   logic                   idx_invalid;
   whacc_pkg::val_type     cur_bin;
   whacc_pkg::val_type     w_ext;
   whacc_pkg::sat_val_type sv_bin;
   whacc_pkg::sat_val_type sv_int;
   whacc_pkg::sat_val_type sv_sub;
   whacc_pkg::sat_val_type sv_add;

   logic                   div_neg;
   logic [QW-1:0]          prob_lim;
   logic                   prob_sat;
   logic [QW-1:0]          prob_mag;
   logic [PW-1:0]          prob_trunc;
   logic signed [PW-1:0]   prob_val;

   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign idx_bad     = idx_ff == BAD_IDX;
   assign idx_invalid = idx_ff > BAD_IDX;
   assign cur_bin     = idx_bad ? bad_ff : whacc_pkg::val_type'(mem_rdata);
   assign w_ext       = {{(VW - whacc_pkg::WEIGHT_W){weight_ff[whacc_pkg::WEIGHT_W-1]}},
                         weight_ff};
   assign sv_bin      = whacc_pkg::add_sat(cur_bin, w_ext);
   assign sv_int      = whacc_pkg::add_sat(integ_ff, w_ext);
   assign sv_sub      = whacc_pkg::sub_sat(integ_ff, bad_ff);
   assign sv_add      = whacc_pkg::add_sat(integ_ff, bad_ff);

   // probability clamp, negative side reaches one step further
   assign div_neg    = res_bval_ff[VW-1] ^ integ_ff[VW-1];
   assign prob_lim   = div_neg ? whacc_pkg::QUOT_NEG_MAX : whacc_pkg::QUOT_POS_MAX;
   assign prob_sat   = div_rsp.ovf || (div_rsp.quot > prob_lim);
   assign prob_mag   = prob_sat ? prob_lim : div_rsp.quot;
   assign prob_trunc = prob_mag[PW-1:0];
   assign prob_val   = div_neg ? -prob_trunc : prob_trunc;

   whacc_ram #(
      .WIDTH (VW),
      .DEPTH (BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (req_bus.bin_index[AW-1:0]),
      .rd_data (mem_rdata)
   );

   whacc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (whacc_pkg::mag(cur_bin)),
      .den   (whacc_pkg::mag(integ_ff)),
      .rsp   (div_rsp)
   );

   whacc_scale u_scale (
      .clock (clock),
      .reset (reset),
      .start (scale_start),
      .integ (integ_ff),
      .ratio (ratio_ff),
      .rsp   (scale_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      weight_in     = weight_ff;
      ratio_in      = ratio_ff;
      integ_in      = integ_ff;
      bad_in        = bad_ff;
      clr_in        = clr_ff;
      res_bval_in   = res_bval_ff;
      res_prob_in   = res_prob_ff;
      res_status_in = res_status_ff;
      res_sat_in    = res_sat_ff;
      res_over_in   = res_over_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_bval_in   = rsp_bval_ff;
      rsp_prob_in   = rsp_prob_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      rsp_over_in   = rsp_over_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = sv_bin.value;
      mem_re        = 1'b0;
      div_start     = 1'b0;
      scale_start   = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         whacc_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADR) begin
               state_in = whacc_pkg::S_IDLE;
            end
         end
         whacc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               mem_re        = 1'b1;
               weight_in     = req_bus.weight;
               ratio_in      = req_bus.ratio;
               res_bval_in   = '0;
               res_prob_in   = '0;
               res_status_in = whacc_pkg::ST_OK;
               res_sat_in    = 1'b0;
               res_over_in   = 1'b0;
               idx_in        = req_bus.bin_index;
               unique case (req_bus.operation)
                  whacc_pkg::OP_STORE: begin
                     state_in = whacc_pkg::S_STORE;
                  end
                  whacc_pkg::OP_STORE_BAD: begin
                     idx_in   = BAD_IDX;
                     state_in = whacc_pkg::S_STORE;
                  end
                  whacc_pkg::OP_SET_BAD: begin
                     state_in = whacc_pkg::S_SUB;
                  end
                  whacc_pkg::OP_READ: begin
                     state_in = whacc_pkg::S_READ;
                  end
               endcase
            end
         end
         whacc_pkg::S_STORE: begin
            if (idx_invalid) begin
               res_status_in = whacc_pkg::ST_BAD_INDEX;
            end else begin
               res_bval_in = sv_bin.value;
               res_sat_in  = sv_bin.sat | sv_int.sat;
               integ_in    = sv_int.value;
               if (idx_bad) begin
                  bad_in = sv_bin.value;
               end else begin
                  mem_we = 1'b1;
               end
            end
            state_in = whacc_pkg::S_OUT;
         end
         whacc_pkg::S_READ: begin
            if (idx_invalid) begin
               res_status_in = whacc_pkg::ST_BAD_INDEX;
               state_in      = whacc_pkg::S_OUT;
            end else begin
               res_bval_in = cur_bin;
               if (integ_ff == '0) begin
                  res_status_in = whacc_pkg::ST_ZERO_INTEGRAL;
                  state_in      = whacc_pkg::S_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = whacc_pkg::S_DIV;
               end
            end
         end
         whacc_pkg::S_DIV: begin
            if (div_rsp.done) begin
               res_prob_in = prob_val;
               res_sat_in  = prob_sat;
               state_in    = whacc_pkg::S_OUT;
            end
         end
         whacc_pkg::S_SUB: begin
            // take the old bad bin back out of the integral before rescaling
            if (bad_ff != '0) begin
               res_over_in = 1'b1;
               integ_in    = sv_sub.value;
               res_sat_in  = sv_sub.sat;
            end
            state_in = whacc_pkg::S_MUL;
         end
         whacc_pkg::S_MUL: begin
            scale_start = 1'b1;
            state_in    = whacc_pkg::S_SCALE;
         end
         whacc_pkg::S_SCALE: begin
            if (scale_rsp.done) begin
               bad_in     = scale_rsp.value;
               res_sat_in = res_sat_ff | scale_rsp.sat;
               state_in   = whacc_pkg::S_ADD;
            end
         end
         whacc_pkg::S_ADD: begin
            integ_in    = sv_add.value;
            res_sat_in  = res_sat_ff | sv_add.sat;
            res_bval_in = bad_ff;
            state_in    = whacc_pkg::S_OUT;
         end
         whacc_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bval_in   = res_bval_ff;
               rsp_prob_in   = res_prob_ff;
               rsp_total_in  = integ_ff;
               rsp_over_in   = res_over_ff;
               rsp_status_in = (res_status_ff == whacc_pkg::ST_OK && res_sat_ff)
                             ? whacc_pkg::ST_SATURATED : res_status_ff;
               state_in      = whacc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = whacc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= whacc_pkg::S_CLEAR;
         clr_ff       <= '0;
         integ_ff     <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         integ_ff     <= integ_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      weight_ff     <= weight_in;
      ratio_ff      <= ratio_in;
      res_bval_ff   <= res_bval_in;
      res_prob_ff   <= res_prob_in;
      res_status_ff <= res_status_in;
      res_sat_ff    <= res_sat_in;
      res_over_ff   <= res_over_in;
      rsp_bval_ff   <= rsp_bval_in;
      rsp_prob_ff   <= rsp_prob_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_over_ff   <= rsp_over_in;
   end

   assign req_bus.ready           = req_ready;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.bin_value       = rsp_bval_ff;
   assign rsp_bus.probability     = rsp_prob_ff;
   assign rsp_bus.total           = rsp_total_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.bad_overwritten = rsp_over_ff;
endmodule

/* hdl/whacc_checker.sv */
// port-level checks for the accumulator, bound to the top level
module whacc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [whacc_pkg::VAL_W-1:0]  rsp_bin_value,
   input logic signed [whacc_pkg::PROB_W-1:0] rsp_probability,
   input logic signed [whacc_pkg::VAL_W-1:0]  rsp_total,
   input whacc_pkg::status_type               rsp_status
);
   // clearing pass follows every reset, so nothing is taken straight after it
   a_no_accept_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_bin_value) && $stable(rsp_total)))
      else $error("stalled result beat changed");

   a_bad_index_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == whacc_pkg::ST_BAD_INDEX) |->
         (rsp_bin_value == '0 && rsp_probability == '0))
      else $error("invalid index beat carries a value");

   a_zero_integral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == whacc_pkg::ST_ZERO_INTEGRAL) |->
         (rsp_total == '0 && rsp_probability == '0))
      else $error("zero integral beat with nonzero total or probability");
endmodule

bind weighted_histogram_accumulator whacc_checker u_whacc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_bin_value   (rsp_bus.bin_value),
   .rsp_probability (rsp_bus.probability),
   .rsp_total       (rsp_bus.total),
   .rsp_status      (rsp_bus.status)
);

/* sim/tb_weighted_histogram_accumulator.sv */
// testbench for the weighted histogram accumulator: predicted bin totals checked beat by beat
`timescale 1ns / 1ps

module tb_weighted_histogram_accumulator;

   localparam int BINS        = 256;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 382;
   localparam int TAIL_CYCLES = 40;
   localparam int VAL_W       = whacc_pkg::VAL_W;
   localparam int PROB_W      = whacc_pkg::PROB_W;
   localparam int RATIO_W     = whacc_pkg::RATIO_W;
   localparam int FRAC_W      = whacc_pkg::FRAC_W;
   localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;

   typedef struct {
      logic signed [VAL_W-1:0]  bin_value;
      logic signed [PROB_W-1:0] probability;
      logic signed [VAL_W-1:0]  total;
      whacc_pkg::status_type    status;
      logic                     bad_overwritten;
   } hist_result_type;

   class histogram_checker;
      longint          bin_totals[BINS+1];
      longint          integral;
      hist_result_type pending_results[$];
      int              mismatch_count;

      function new();
         foreach (bin_totals[i]) bin_totals[i] = 0;
         integral       = 0;
         mismatch_count = 0;
      endfunction

      function longint sat_limit(longint v, inout bit sat);
         if (v > SUM_MAX) begin
            sat = 1'b1;
            return SUM_MAX;
         end
         if (v < SUM_MIN) begin
            sat = 1'b1;
            return SUM_MIN;
         end
         return v;
      endfunction

      function longint unsigned abs_val(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      // integral times ratio on magnitudes, truncated toward zero, sign put back afterwards
      function longint scaled_fraction(longint a, logic [RATIO_W-1:0] r, inout bit sat);
         logic [95:0] prod;
         prod = 96'(abs_val(a)) * 96'(r);
         prod = prod >> FRAC_W;
         if (a < 0) begin
            if (prod > 96'h8000_0000_0000) begin
               sat = 1'b1;
               return SUM_MIN;
            end
            return -longint'(prod[63:0]);
         end
         if (prod > 96'(SUM_MAX)) begin
            sat = 1'b1;
            return SUM_MAX;
         end
         return longint'(prod[63:0]);
      endfunction

      function void note_request(whacc_pkg::op_type op, logic [8:0] idx,
                                 logic signed [31:0] w, logic [31:0] r);
         hist_result_type    res;
         longint             wv;
         longint             bval;
         longint             prob;
         longint unsigned    q;
         bit                 sat;
         bit                 neg;
         int unsigned        slot;
         wv   = longint'(w);
         bval = 0;
         prob = 0;
         sat  = 1'b0;
         res.status          = whacc_pkg::ST_OK;
         res.bad_overwritten = 1'b0;
         slot = (op == whacc_pkg::OP_STORE_BAD) ? BINS : int'(idx);
         case (op)
            whacc_pkg::OP_STORE, whacc_pkg::OP_STORE_BAD: begin
               if (slot > BINS) begin
                  res.status = whacc_pkg::ST_BAD_INDEX;
               end else begin
                  bin_totals[slot] = sat_limit(bin_totals[slot] + wv, sat);
                  integral         = sat_limit(integral + wv, sat);
                  bval             = bin_totals[slot];
               end
            end
            whacc_pkg::OP_SET_BAD: begin
               // the old bad bin leaves the integral before the new one is derived
               if (bin_totals[BINS] != 0) begin
                  res.bad_overwritten = 1'b1;
                  integral = sat_limit(integral - bin_totals[BINS], sat);
               end
               bin_totals[BINS] = scaled_fraction(integral, r, sat);
               integral         = sat_limit(integral + bin_totals[BINS], sat);
               bval             = bin_totals[BINS];
            end
            default: begin
               if (slot > BINS) begin
                  res.status = whacc_pkg::ST_BAD_INDEX;
               end else begin
                  bval = bin_totals[slot];
                  if (integral == 0) begin
                     res.status = whacc_pkg::ST_ZERO_INTEGRAL;
                  end else begin
                     q   = (abs_val(bval) << FRAC_W) / abs_val(integral);
                     neg = (bval < 0) != (integral < 0);
                     if (neg) begin
                        if (q > 131072) begin
                           q   = 131072;
                           sat = 1'b1;
                        end
                        prob = -longint'(q);
                     end else begin
                        if (q > 131071) begin
                           q   = 131071;
                           sat = 1'b1;
                        end
                        prob = longint'(q);
                     end
                  end
               end
            end
         endcase
         if (res.status == whacc_pkg::ST_OK && sat) res.status = whacc_pkg::ST_SATURATED;
         res.bin_value   = bval[VAL_W-1:0];
         res.probability = prob[PROB_W-1:0];
         res.total       = integral[VAL_W-1:0];
         pending_results = {pending_results, res};
      endfunction

      function void check_result(hist_result_type got);
         hist_result_type want;
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.bin_value !== want.bin_value) begin
            $error("bin_value: expected %0d, got %0d", want.bin_value, got.bin_value);
            mismatch_count++;
         end
         if (got.probability !== want.probability) begin
            $error("probability: expected %0d, got %0d", want.probability, got.probability);
            mismatch_count++;
         end
         if (got.total !== want.total) begin
            $error("total: expected %0d, got %0d", want.total, got.total);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.bad_overwritten !== want.bad_overwritten) begin
            $error("bad_overwritten: expected %0d, got %0d", want.bad_overwritten,
                   got.bad_overwritten);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count = 0;
   int   idle_tab[4]  = '{0, 46, 0, 21};
   int   stall_tab[4] = '{0, 0, 46, 21};

   histogram_checker hist_chk = new();

   whacc_req_if #(.BINS(BINS)) req_bus ();
   whacc_rsp_if                rsp_bus ();

   weighted_histogram_accumulator #(.BINS(BINS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: ready changes on the falling edge, beats are taken on the rising one
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      hist_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.bin_value       = rsp_bus.bin_value;
         got.probability     = rsp_bus.probability;
         got.total           = rsp_bus.total;
         got.status          = rsp_bus.status;
         got.bad_overwritten = rsp_bus.bad_overwritten;
         hist_chk.check_result(got);
      end
   end

   // entered and left at a falling edge
   task automatic send_item(whacc_pkg::op_type op, logic [8:0] idx, logic signed [31:0] w,
                            logic [31:0] r);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.bin_index <= idx;
      req_bus.weight    <= w;
      req_bus.ratio     <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      hist_chk.note_request(op, idx, w, r);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (hist_chk.pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      whacc_pkg::op_type  op;
      logic [8:0]         idx;
      logic signed [31:0] w;
      logic [31:0]        r;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 45)      op = whacc_pkg::OP_STORE;
      else if (pick < 55) op = whacc_pkg::OP_STORE_BAD;
      else if (pick < 65) op = whacc_pkg::OP_SET_BAD;
      else                op = whacc_pkg::OP_READ;
      // mostly a handful of bins so that reads see real totals
      pick = $urandom_range(99);
      if (pick < 60)      idx = 9'($urandom_range(15));
      else if (pick < 80) idx = 9'($urandom_range(BINS));
      else if (pick < 85) idx = 9'(BINS);
      else                idx = 9'($urandom_range(511, BINS + 1));
      pick = $urandom_range(9);
      if (pick < 6)      w = 32'($urandom_range(32'h80000)) - 32'h40000;
      else if (pick < 9) w = $urandom();
      else               w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      pick = $urandom_range(9);
      if (pick < 7)      r = $urandom_range(32'h18000);
      else if (pick < 9) r = $urandom();
      else               r = 32'd0;
      send_item(op, idx, w, r);
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = whacc_pkg::OP_STORE;
      req_bus.bin_index = '0;
      req_bus.weight    = '0;
      req_bus.ratio     = '0;
      idle_pct          = 0;
      stall_pct         = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // read before anything is stored: zero integral
      send_item(whacc_pkg::OP_READ,      9'd5,   32'sd0,        32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd0,   32'h7FFF_FFFF, 32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd255, 32'h8000_0000, 32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd256, 32'h0001_0000, 32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd257, 32'h0000_1234, 32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(whacc_pkg::OP_READ,      9'd300, 32'sd0,        32'd0);
      send_item(whacc_pkg::OP_STORE_BAD, 9'h1AA, -32'sd5,       32'd0);
      // bins far larger than the integral: probability clamps both ways
      send_item(whacc_pkg::OP_READ,      9'd0,   32'sd0,        32'd0);
      send_item(whacc_pkg::OP_READ,      9'd255, 32'sd0,        32'd0);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'h0000_8000);
      send_item(whacc_pkg::OP_SET_BAD,   9'd3,   32'sd0,        32'hFFFF_FFFF);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'hFFFF_FFFF);
      send_item(whacc_pkg::OP_STORE_BAD, 9'd0,   32'h7FFF_FFFF, 32'd0);
      send_item(whacc_pkg::OP_READ,      9'd256, 32'sd0,        32'd0);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd1,   32'hFFFF_FFFF, 32'd0);
      send_item(whacc_pkg::OP_READ,      9'd1,   32'sd0,        32'd0);
      // drive the integral negative, then saturate it low through the bad bin
      send_item(whacc_pkg::OP_STORE,     9'd2,   32'h8000_0000, 32'd0);
      send_item(whacc_pkg::OP_STORE,     9'd2,   32'h8000_0000, 32'd0);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'hFFFF_FFFF);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'hFFFF_FFFF);
      send_item(whacc_pkg::OP_READ,      9'd2,   32'sd0,        32'd0);
      send_item(whacc_pkg::OP_READ,      9'd256, 32'sd0,        32'd0);
      send_item(whacc_pkg::OP_SET_BAD,   9'd0,   32'sd0,        32'd0);
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         repeat (PHASE_ITEMS) send_random();
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (hist_chk.pending_results.size() != 0)
         $error("%0d results never arrived", hist_chk.pending_results.size());
      if (hist_chk.mismatch_count == 0 && hist_chk.pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
